// ----- design/cfa_pkg.sv -----
package cfa_pkg;

  localparam int FRAME_W  = 20;
  localparam int COUNT_W  = 15;
  localparam int POS_W    = 16;
  localparam int LANES    = 4;
  localparam int WORD_W   = 8;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_BLOCK   = 2'd2,
    FN_INIT    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    RS_OK        = 3'd0,
    RS_NO_SPACE  = 3'd1,
    RS_RANGE     = 3'd2,
    RS_NOT_HEAD  = 3'd3,
    RS_OUTSIDE   = 3'd4
  } status_t;

  // per-frame map codes
  typedef enum logic [1:0] {
    FS_FREE    = 2'd0,
    FS_HEAD    = 2'd1,
    FS_BLOCKED = 2'd2,
    FS_ALLOC   = 2'd3
  } fstate_t;

  // what the lane unit does to one map word
  typedef enum logic [1:0] {
    OP_SCAN    = 2'd0,
    OP_MARK    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_BLOCK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_CHECK = 3'd1,
    S_SWEEP = 3'd2,
    S_CLEAR = 3'd3,
    S_DONE  = 3'd4
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] lo;
    logic [POS_W-1:0]   lim;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] run;
    logic [COUNT_W-1:0] start;
    logic               active;
    logic [COUNT_W-1:0] fc;
  } lane_ctl_t;

  typedef struct packed {
    logic [WORD_W-1:0]  data;
    logic               we;
    logic [COUNT_W-1:0] run;
    logic [COUNT_W-1:0] start;
    logic               found;
    logic               active;
    logic               stop;
    logic               not_head;
    logic [COUNT_W-1:0] fc;
  } lane_res_t;

endpackage

// ----- design/cfa_map_ram.sv -----
module cfa_map_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [cfa_pkg::WORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [cfa_pkg::WORD_W-1:0] rdata
);
  import cfa_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/cfa_lane_unit.sv -----
module cfa_lane_unit (
  input  cfa_pkg::lane_ctl_t          ctl,
  input  logic [cfa_pkg::WORD_W-1:0]  rd_word,
  output cfa_pkg::lane_res_t          res
);
  import cfa_pkg::*;

  // one map word of four frames per call, lanes walked low to high
  always_comb begin : lanes
    logic [POS_W-1:0] f;
    logic [1:0]       st;
    res.data     = rd_word;
    res.we       = (ctl.op != OP_SCAN);
    res.run      = ctl.run;
    res.start    = ctl.start;
    res.found    = 1'b0;
    res.active   = ctl.active;
    res.stop     = 1'b0;
    res.not_head = 1'b0;
    res.fc       = ctl.fc;
    for (int l = 0; l < LANES; l++) begin
      f  = ctl.pos + POS_W'(l);
      st = res.data[2*l +: 2];
      case (ctl.op)
        OP_SCAN: begin
          if (!res.found && f < ctl.lim) begin
            if (st == FS_FREE) begin
              if (res.run == '0) begin
                res.start = f[COUNT_W-1:0];
              end
              res.run = res.run + COUNT_W'(1);
              if (res.run == ctl.cnt) begin
                res.found = 1'b1;
              end
            end else begin
              res.run = '0;
            end
          end
        end
        OP_MARK: begin
          if (f >= {1'b0, ctl.lo} && f < ctl.lim) begin
            st = (f == {1'b0, ctl.lo}) ? FS_HEAD : FS_ALLOC;
          end
        end
        OP_BLOCK: begin
          if (f >= {1'b0, ctl.lo} && f < ctl.lim) begin
            if (st == FS_FREE && res.fc != '0) begin
              res.fc = res.fc - COUNT_W'(1);
            end
            st = FS_BLOCKED;
          end
        end
        OP_RELEASE: begin
          if (!res.stop) begin
            if (f == {1'b0, ctl.lo}) begin
              if (st == FS_HEAD) begin
                st = FS_FREE;
                res.active = 1'b1;
                if ({1'b0, res.fc} < ctl.lim) begin
                  res.fc = res.fc + COUNT_W'(1);
                end
              end else begin
                res.not_head = 1'b1;
                res.stop     = 1'b1;
              end
            end else if (res.active) begin
              if (f < ctl.lim && st == FS_ALLOC) begin
                st = FS_FREE;
                if ({1'b0, res.fc} < ctl.lim) begin
                  res.fc = res.fc + COUNT_W'(1);
                end
              end else begin
                res.active = 1'b0;
                res.stop   = 1'b1;
              end
            end
          end
        end
        default: begin
          st = st;
        end
      endcase
      res.data[2*l +: 2] = st;
    end
  end

endmodule

// ----- design/contiguous_frame_allocator.sv -----
// contiguous frame allocator: first-fit runs of page frames over a 2-bit-per-frame map
//
// channels
//   s_* : one command per transfer; s_tuser is the function (allocate, release,
//         mark inaccessible, initialize), s_tdata carries frame number and count
//   m_* : one result per command; m_tuser is the status code, m_tdata carries
//         the head frame of an allocated run and the free frame count
//   cfg_*: register writes (pool base, pool size, reserve first frame)
// timing
//   map words hold four frames; a shared lane unit updates one word per cycle
//   while the next word is read; a command that fails its checks skips the map,
//   a release or block sweeps the words of its range, allocate scans and then
//   marks the run, and initialize clears the whole map; s_tready is high only
//   while idle, so a new command is taken only once the previous result has
//   been loaded into the output register
// reset
//   the map is cleared over all of its words (frame 0 left as a head);
//   commands wait meanwhile, config is still taken
// stalls
//   a finished result waits in the output register while the next command is
//   accepted and worked on; a second result waits until m_tready frees it
module contiguous_frame_allocator #(
  parameter int MAX_POOL_FRAMES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  // command: tuser = func[1:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata = frame_number[19:0], frame_count[34:20], zero pad [39:35]
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  // result: tuser = status[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata = result_frame[19:0], free_frames[34:20], zero pad [39:35]
  output logic [39:0] m_tdata,
  output logic [2:0]  m_tuser,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import cfa_pkg::*;

  localparam int DEPTH = MAX_POOL_FRAMES / LANES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RST_N = (MAX_POOL_FRAMES < 16384) ? MAX_POOL_FRAMES : 16384;
  localparam logic [16:0] MAX_V = 17'(MAX_POOL_FRAMES);

  localparam logic [1:0] CFG_BASE    = 2'd0;
  localparam logic [1:0] CFG_COUNT   = 2'd1;
  localparam logic [1:0] CFG_RESERVE = 2'd2;

  // config registers
  logic [FRAME_W-1:0] pool_base;
  logic [COUNT_W-1:0] pool_cnt;
  logic               reserve;

  state_t state, state_next;
  op_t    op;

  // command
  func_t              func_q;
  logic [FRAME_W-1:0] fno_q;
  logic [COUNT_W-1:0] cnt_q;

  // sweep control
  logic [POS_W-1:0]   issue_pos;
  logic               p_valid;
  logic [POS_W-1:0]   p_pos;
  logic [COUNT_W-1:0] lo;
  logic [POS_W-1:0]   lim;
  logic [COUNT_W-1:0] run;
  logic [COUNT_W-1:0] start;
  logic               active;
  logic [COUNT_W-1:0] free_count;

  status_t            status_q;
  logic [FRAME_W-1:0] result_q;

  logic [AW-1:0]      clr_addr;
  logic               clr_reply;
  logic               init_head;

  // control strobes
  logic               in_fire;
  logic               issue;
  logic               finish;
  logic               load_out;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  rd_word;

  // pool checks
  logic [COUNT_W-1:0] pool_n;
  logic [COUNT_W-1:0] idx;
  logic               rel_out;
  logic               blk_bad;
  logic               p_last;
  logic               init_rsv;

  lane_ctl_t lctl;
  lane_res_t lres;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;

  // effective pool size, clamped to the map depth
  assign pool_n = ({2'b00, pool_cnt} > MAX_V) ? COUNT_W'(MAX_V) : pool_cnt;

  assign idx     = COUNT_W'(fno_q - pool_base);
  assign rel_out = (fno_q < pool_base) ||
                   ({1'b0, fno_q} >= {1'b0, pool_base} + 21'(pool_n));
  assign blk_bad = (fno_q < pool_base) ||
                   ({1'b0, fno_q} + 21'(cnt_q) > {1'b0, pool_base} + 21'(pool_n));
  assign p_last  = ({1'b0, p_pos} + 17'd4) >= {1'b0, lim};
  assign init_rsv = reserve && (pool_n != '0);

  always_comb begin
    lctl.op     = op;
    lctl.pos    = p_pos;
    lctl.lo     = lo;
    lctl.lim    = lim;
    lctl.cnt    = cnt_q;
    lctl.run    = run;
    lctl.start  = start;
    lctl.active = active;
    lctl.fc     = free_count;
  end

  cfa_lane_unit u_lane (
    .ctl     (lctl),
    .rd_word (rd_word),
    .res     (lres)
  );

  cfa_map_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (issue_pos[AW+1:2]),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    finish     = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = p_pos[AW+1:2];
    mem_wdata  = lres.data;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (func_q)
          FN_ALLOC: begin
            if (cnt_q == '0 || cnt_q > free_count || cnt_q > pool_n) begin
              state_next = S_DONE;
            end else begin
              state_next = S_SWEEP;
            end
          end
          FN_RELEASE: state_next = rel_out ? S_DONE : S_SWEEP;
          FN_BLOCK:   state_next = (blk_bad || cnt_q == '0) ? S_DONE : S_SWEEP;
          FN_INIT:    state_next = S_CLEAR;
          default:    state_next = S_DONE;
        endcase
      end
      S_SWEEP: begin
        // read of the next word overlaps the write-back of the current one
        finish = p_valid && (lres.stop || lres.found || p_last);
        issue  = !finish && (issue_pos < lim);
        mem_we = p_valid && lres.we;
        if (finish && !(op == OP_SCAN && lres.found)) begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = (clr_addr == '0 && init_head) ? WORD_W'(FS_HEAD) : '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = clr_reply ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      pool_cnt   <= COUNT_W'(16384);
      reserve    <= 1'b1;
      free_count <= COUNT_W'(RST_N - 1);
      init_head  <= 1'b1;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      p_valid    <= 1'b0;
      m_tvalid   <= 1'b0;
      op         <= OP_SCAN;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE:    pool_base <= cfg_data;
          CFG_COUNT:   pool_cnt  <= cfg_data[COUNT_W-1:0];
          CFG_RESERVE: reserve   <= cfg_data[0];
          default:     ;
        endcase
      end

      if (in_fire) begin
        func_q   <= func_t'(s_tuser);
        fno_q    <= s_tdata[19:0];
        cnt_q    <= s_tdata[34:20];
        status_q <= RS_OK;
        result_q <= '0;
      end

      p_valid <= issue;
      p_pos   <= issue_pos;
      if (issue) begin
        issue_pos <= issue_pos + POS_W'(LANES);
      end

      case (state)
        S_CHECK: begin
          case (func_q)
            FN_ALLOC: begin
              if (cnt_q == '0) begin
                status_q <= RS_RANGE;
              end else if (cnt_q > free_count || cnt_q > pool_n) begin
                status_q <= RS_NO_SPACE;
              end else begin
                op        <= OP_SCAN;
                issue_pos <= '0;
                lim       <= {1'b0, pool_n};
                run       <= '0;
                start     <= '0;
              end
            end
            FN_RELEASE: begin
              if (rel_out) begin
                status_q <= RS_OUTSIDE;
              end else begin
                op        <= OP_RELEASE;
                issue_pos <= {1'b0, idx[COUNT_W-1:2], 2'b00};
                lo        <= idx;
                lim       <= {1'b0, pool_n};
                active    <= 1'b0;
              end
            end
            FN_BLOCK: begin
              if (blk_bad) begin
                status_q <= RS_RANGE;
              end else begin
                op        <= OP_BLOCK;
                issue_pos <= {1'b0, idx[COUNT_W-1:2], 2'b00};
                lo        <= idx;
                lim       <= {1'b0, idx} + {1'b0, cnt_q};
              end
            end
            FN_INIT: begin
              init_head  <= init_rsv;
              free_count <= pool_n - COUNT_W'(init_rsv);
              clr_addr   <= '0;
              clr_reply  <= 1'b1;
            end
            default: ;
          endcase
        end
        S_SWEEP: begin
          if (p_valid) begin
            run        <= lres.run;
            start      <= lres.start;
            active     <= lres.active;
            free_count <= lres.fc;
          end
          if (finish) begin
            if (op == OP_SCAN) begin
              if (lres.found) begin
                // run found: switch to marking head and followers
                op         <= OP_MARK;
                lo         <= lres.start;
                lim        <= {1'b0, lres.start} + {1'b0, cnt_q};
                issue_pos  <= {1'b0, lres.start[COUNT_W-1:2], 2'b00};
                free_count <= (cnt_q > lres.fc) ? '0 : lres.fc - cnt_q;
                result_q   <= pool_base + FRAME_W'(lres.start);
              end else begin
                status_q <= RS_NO_SPACE;
              end
            end
            if (op == OP_RELEASE && lres.not_head) begin
              status_q <= RS_NOT_HEAD;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        default: ;
      endcase

      if (load_out) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'b00000, free_count, result_q};
        m_tuser  <= status_q;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a word in flight always belongs to the sweep that read it
  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == S_SWEEP))
    else $error("map word in flight outside sweep");

  // write-back never lands beyond the range being swept
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_SWEEP) |-> (p_pos < lim))
    else $error("map write beyond sweep limit");

  // a finished command with a free output register is handed over at once
  a_done_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !m_tvalid) |=> (state == S_IDLE && m_tvalid))
    else $error("result not loaded into output register");

  // reset always starts the map clearing pass
  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> (state == S_CLEAR && clr_addr == '0))
    else $error("clearing pass not started after reset");
`endif

endmodule

// ----- test/contiguous_frame_allocator_tb.sv -----
module contiguous_frame_allocator_tb;
  import cfa_pkg::*;

  localparam int MAP_FRAMES  = 16384;       // map depth of the block under test
  localparam int CYCLE_LIMIT = 10_000_000;  // slowest legal run taken several times over
  localparam int HOLD_CYCLES = 400;         // long receiver hold-off
  localparam int HOLD_AFTER  = 70;          // commands taken before the hold-off starts
  localparam int SETTLE      = 64;          // quiet cycles after the last result

  // register indexes of the write channel
  localparam logic [1:0] REG_POOL_BASE     = 2'd0;
  localparam logic [1:0] REG_POOL_FRAMES   = 2'd1;
  localparam logic [1:0] REG_RESERVE_FIRST = 2'd2;

  typedef struct {
    func_t              fn;
    logic [FRAME_W-1:0] fno;
    logic [COUNT_W-1:0] cnt;
  } command_t;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    status_t            st;
    logic [COUNT_W-1:0] frames_left;
  } result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // frame_number[19:0], frame_count[34:20], zero pad
  logic [1:0]  s_tuser;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // result_frame[19:0], free_frames[34:20], zero pad
  logic [2:0]  m_tuser;   // status[2:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  contiguous_frame_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // frame map predictor: its own copy of the map, the free counter and registers
  // ---------------------------------------------------------------------------
  fstate_t            pool_map [MAP_FRAMES];
  int unsigned        pool_free;
  logic [FRAME_W-1:0] cfg_base;
  logic [COUNT_W-1:0] cfg_frames;
  logic               cfg_reserve;

  command_t           command_q[$];        // commands waiting for the driver
  result_t            pending_results[$];  // predicted results, oldest first
  logic [FRAME_W-1:0] live_heads[$];       // heads handed out, fodder for releases

  int commands_taken;
  int results_seen;
  int errors;
  int pool_settings;
  int status_seen [5];
  int cycle_count;

  // register value above the map depth is clipped to it
  function automatic int unsigned pool_size();
    return (cfg_frames > MAP_FRAMES) ? MAP_FRAMES : cfg_frames;
  endfunction

  // counter saturates at zero going down
  function automatic void take_free(input int unsigned k);
    pool_free = (k > pool_free) ? 0 : pool_free - k;
  endfunction

  // and at the pool size going up
  function automatic void give_one(input int unsigned n);
    if (pool_free < n) pool_free++;
  endfunction

  function automatic void clear_pool();
    int unsigned n;
    n = pool_size();
    foreach (pool_map[i]) pool_map[i] = FS_FREE;
    pool_free = n;
    if (cfg_reserve && n > 0) begin
      pool_map[0] = FS_HEAD;
      pool_free   = n - 1;
    end
    live_heads.delete();
  endfunction

  function automatic result_t apply_command(input command_t c);
    result_t     r;
    int unsigned n, base, run, start, idx, was_free;
    bit          found;
    n       = pool_size();
    base    = cfg_base;
    r.frame = '0;
    r.st    = RS_OK;
    case (c.fn)
      FN_ALLOC: begin
        if (c.cnt == 0) begin
          r.st = RS_RANGE;
        end else if (c.cnt > pool_free || c.cnt > n) begin
          r.st = RS_NO_SPACE;
        end else begin
          // first fit over free frames
          run   = 0;
          start = 0;
          found = 0;
          for (int unsigned i = 0; i < n && !found; i++) begin
            if (pool_map[i] == FS_FREE) begin
              if (run == 0) start = i;
              run++;
              if (run == c.cnt) found = 1;
            end else begin
              run = 0;
            end
          end
          if (!found) begin
            r.st = RS_NO_SPACE;
          end else begin
            pool_map[start] = FS_HEAD;
            for (int unsigned i = 1; i < c.cnt; i++) pool_map[start + i] = FS_ALLOC;
            take_free(c.cnt);
            r.frame = FRAME_W'(base + start);
            live_heads.push_back(r.frame);
          end
        end
      end
      FN_RELEASE: begin
        if (c.fno < base || c.fno >= base + n) begin
          r.st = RS_OUTSIDE;
        end else begin
          idx = c.fno - base;
          if (pool_map[idx] != FS_HEAD) begin
            r.st = RS_NOT_HEAD;
          end else begin
            // head plus the allocated tail, never past the pool end
            pool_map[idx] = FS_FREE;
            give_one(n);
            for (int unsigned i = idx + 1; i < n && pool_map[i] == FS_ALLOC; i++) begin
              pool_map[i] = FS_FREE;
              give_one(n);
            end
          end
        end
      end
      FN_BLOCK: begin
        if (c.fno < base || int'(c.fno) + int'(c.cnt) > base + n) begin
          r.st = RS_RANGE;
        end else begin
          // every frame of the run is blocked, only free ones leave the count
          idx      = c.fno - base;
          was_free = 0;
          for (int unsigned i = 0; i < c.cnt; i++) begin
            if (pool_map[idx + i] == FS_FREE) was_free++;
            pool_map[idx + i] = FS_BLOCKED;
          end
          take_free(was_free);
        end
      end
      default: clear_pool();
    endcase
    r.frames_left = COUNT_W'(pool_free);
    status_seen[r.st]++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // command driver: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  command_t offered;
  int       burst_left;
  int       gap_left;

  always @(posedge clk) begin : drive_commands
    bit busy;
    busy = s_tvalid && !s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      // a transfer moves the command into the predictor
      if (s_tvalid && s_tready) begin
        pending_results.push_back(apply_command(offered));
        commands_taken++;
      end
      if (!busy) begin
        if (burst_left == 0) begin
          // now and then a long stretch without gaps
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
          gap_left   = $urandom_range(0, 7);
        end
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (command_q.size() != 0) begin
          offered = command_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= offered.fn;
          s_tdata  <= {5'b0, offered.cnt, offered.fno};
          burst_left--;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: stall pattern of its own, plus one long hold-off
  // ---------------------------------------------------------------------------
  logic hold_rx;
  int   pat_left;
  int   pat_mode;

  always @(posedge clk) begin : drive_ready
    bit take;
    if (pat_left == 0) begin
      pat_left = $urandom_range(8, 48);
      pat_mode = $urandom_range(0, 3);
    end
    pat_left--;
    case (pat_mode)
      0, 1:    take = 1'b1;                            // always ready
      2:       take = 1'($urandom_range(0, 1));        // half the time
      default: take = ($urandom_range(0, 3) == 0);     // mostly stalled
    endcase
    m_tready <= take && !hold_rx;
  end

  // block fills up: one result parked, the next command done, input stalled
  initial begin
    wait (commands_taken >= HOLD_AFTER);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors++;
    if (errors <= 40)
      $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[19:0] !== want.frame)
          report_mismatch("result_frame", m_tdata[19:0], want.frame);
        if (m_tuser !== want.st)
          report_mismatch("status", m_tuser, want.st);
        if (m_tdata[34:20] !== want.frames_left)
          report_mismatch("free_frames", m_tdata[34:20], want.frames_left);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic send(input func_t fn, input logic [FRAME_W-1:0] fno,
                      input logic [COUNT_W-1:0] cnt);
    command_t c;
    // keep the queue short so releases pick up fresh heads
    while (command_q.size() >= 2) @(posedge clk);
    c.fn  = fn;
    c.fno = fno;
    c.cnt = cnt;
    command_q.push_back(c);
  endtask

  // sender pauses until every outstanding result is in
  task automatic drain();
    do @(negedge clk);
    while (command_q.size() != 0 || s_tvalid || pending_results.size() != 0);
    @(posedge clk);
  endtask

  // one register write; valid stays up for the next one
  task automatic cfg_write(input logic [1:0] idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POOL_BASE:     cfg_base    = val;
      REG_POOL_FRAMES:   cfg_frames  = val[COUNT_W-1:0];
      REG_RESERVE_FIRST: cfg_reserve = val[0];
      default: ;
    endcase
  endtask

  task automatic set_pool(input logic [19:0] base, input int frames, input bit reserve);
    cfg_write(REG_POOL_BASE, base);
    cfg_write(REG_POOL_FRAMES, 20'(frames));
    cfg_write(REG_RESERVE_FIRST, 20'(reserve));
    cfg_valid <= 1'b0;
    @(posedge clk);
    pool_settings++;
  endtask

  // mostly sensible traffic against the current pool, some noise
  task automatic random_items(input int k);
    int unsigned        n, pick, off, span;
    logic [FRAME_W-1:0] fno;
    logic [COUNT_W-1:0] cnt;
    func_t              fn;
    for (int j = 0; j < k; j++) begin
      n    = pool_size();
      pick = $urandom_range(0, 99);
      fn   = FN_ALLOC;
      fno  = FRAME_W'($urandom);
      cnt  = '0;
      if (pick < 40) begin
        // short runs mostly, capped at 64 frames in big pools
        span = (n > 256) ? 64 : n / 4;
        cnt  = (pick < 34) ? COUNT_W'($urandom_range(1, span))
                           : COUNT_W'($urandom_range(0, n + 1));
      end else if (pick < 70) begin
        fn = FN_RELEASE;
        if (live_heads.size() != 0 && pick < 64) begin
          off = $urandom_range(0, live_heads.size() - 1);
          fno = live_heads[off];
          live_heads.delete(off);
        end else begin
          fno = FRAME_W'(cfg_base + $urandom_range(0, n - 1));
        end
        cnt = COUNT_W'($urandom_range(0, 16384));
      end else if (pick < 82) begin
        // mark runs, a few of them spilling past the pool end
        fn  = FN_BLOCK;
        off = $urandom_range(0, n - 1);
        fno = FRAME_W'(cfg_base + off);
        cnt = (pick < 79) ? COUNT_W'($urandom_range(0, (n - off < 4) ? n - off : 4))
                          : COUNT_W'($urandom_range(0, 8));
      end else if (pick < 86) begin
        fn  = FN_INIT;
      end else begin
        fn  = func_t'($urandom_range(0, 3));
        cnt = COUNT_W'($urandom_range(0, 16384));
      end
      send(fn, fno, cnt);
    end
  endtask

  task automatic run_phase(input logic [19:0] base, input int frames, input bit reserve,
                           input bit with_init, input int k);
    drain();
    set_pool(base, frames, reserve);
    if (with_init) send(FN_INIT, FRAME_W'($urandom), COUNT_W'($urandom_range(0, 16384)));
    random_items(k);
  endtask

  initial begin
    logic [19:0] b;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = FN_ALLOC;
    m_tready    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_POOL_BASE;
    cfg_data    = '0;
    hold_rx     = 1'b0;
    // reset values: base 0, full size, first frame reserved
    cfg_base    = '0;
    cfg_frames  = COUNT_W'(MAP_FRAMES);
    cfg_reserve = 1'b1;
    clear_pool();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // default pool: extremes of the run length, release corners, marking
    send(FN_ALLOC, 20'h0, 15'd0);          // zero length
    send(FN_ALLOC, 20'h0, 15'd16384);      // more than free
    send(FN_ALLOC, 20'h0, 15'd16383);      // whole pool behind the reserved frame
    send(FN_ALLOC, 20'h0, 15'd1);          // nothing left
    send(FN_RELEASE, 20'd1, 15'd0);
    send(FN_RELEASE, 20'd0, 15'd0);        // reserved head
    send(FN_RELEASE, 20'd5, 15'd0);        // not a head
    send(FN_RELEASE, 20'd16384, 15'd0);    // one past the pool
    send(FN_BLOCK, 20'd16380, 15'd4);      // ends exactly at the pool end
    send(FN_BLOCK, 20'd16381, 15'd4);      // one past it
    send(FN_ALLOC, 20'hFFFFF, 15'd3);
    send(FN_BLOCK, 20'd0, 15'd5);          // over head, tail and free frames
    send(FN_RELEASE, 20'd0, 15'd0);        // head now blocked
    send(FN_INIT, 20'hFFFFF, 15'd16384);

    // smallest pool at the top of the frame space, map kept across the size change
    drain();
    set_pool(20'hFFFFC, 8, 1'b0);
    send(FN_ALLOC, 20'h0, 15'd8);          // old reserved head still in the map
    send(FN_INIT, 20'h0, 15'd0);
    send(FN_ALLOC, 20'h0, 15'd4);
    send(FN_ALLOC, 20'h0, 15'd4);          // head frame number wraps to zero
    send(FN_ALLOC, 20'h0, 15'd1);
    send(FN_RELEASE, 20'hFFFFC, 15'd0);
    send(FN_BLOCK, 20'h00010, 15'd1);      // below the base
    send(FN_RELEASE, 20'h00010, 15'd0);    // below the base
    send(FN_BLOCK, 20'hFFFFF, 15'd6);      // past the pool end
    send(FN_BLOCK, 20'hFFFFE, 15'd0);      // empty run, in range
    send(FN_BLOCK, 20'hFFFFD, 15'd3);

    // grow without initialize: marking drives the stale counter to zero
    drain();
    b = 20'($urandom);
    set_pool(b, 64, 1'b1);
    send(FN_BLOCK, b, 15'd64);
    send(FN_INIT, b, 15'd64);
    random_items(18);

    // shrink without initialize: counter above the pool size; then a larger pool, initialized
    run_phase(20'($urandom), 8, 1'($urandom_range(0, 1)), 1'b0, 15);
    run_phase(20'($urandom), 32, 1'b0, 1'b1, 25);

    // largest pool, no reservation: one run over every frame
    drain();
    set_pool(20'h0, MAP_FRAMES, 1'b0);
    send(FN_INIT, 20'h0, 15'd0);
    send(FN_ALLOC, 20'h0, 15'd16384);
    send(FN_RELEASE, 20'h0, 15'd0);
    random_items(5);

    run_phase(20'hFFFFF, 256, 1'b1, 1'b1, 15);
    run_phase(20'($urandom), 128, 1'($urandom_range(0, 1)), 1'b0, 12);
    run_phase(20'($urandom), 16, 1'b1, 1'b1, 16);

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("%0d commands over %0d pool settings, %0d results checked, %0d mismatches",
             commands_taken, pool_settings + 1, results_seen, errors);
    $display("status mix: ok %0d, no space %0d, range %0d, not head %0d, outside %0d",
             status_seen[RS_OK], status_seen[RS_NO_SPACE], status_seen[RS_RANGE],
             status_seen[RS_NOT_HEAD], status_seen[RS_OUTSIDE]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/cfa_pkg.sv
design/cfa_map_ram.sv
design/cfa_lane_unit.sv
design/contiguous_frame_allocator.sv
test/contiguous_frame_allocator_tb.sv
